>>> sv/fir_decimator_by_two_framer_unit_macros.svh
// assertion macros for the half-rate fir decimator checker
// expects clk and rst_n in the scope of each use
`ifndef FIR_DECIMATOR_BY_TWO_FRAMER_UNIT_MACROS_SVH
`define FIR_DECIMATOR_BY_TWO_FRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define FDF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdf implication check failed");

// next-cycle implication
`define FDF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdf next-cycle check failed");

`endif

>>> sv/fdf_pkg.sv
// shared types, constants and coefficient table of the half-rate fir decimator
// no dependencies
`default_nettype none

package fdf_pkg;

    localparam int TAP_COUNT         = 31;
    localparam int MID_TAP           = (TAP_COUNT - 1) / 2;
    localparam int HIST_AW           = 5;
    localparam int SAMPLE_W          = 16;
    localparam int COEF_W            = 16;
    localparam int PROD_W            = SAMPLE_W + 1 + COEF_W;
    localparam int ACC_W             = 34;
    localparam int ROUND_SHIFT       = 15;
    localparam int ROUND_BIAS        = 1 << (ROUND_SHIFT - 1);
    localparam int FDF_FRAME_SAMPLES = 480;
    localparam int FDF_QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       compute;
    } fdf_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_DONE
    } fdf_state_t;

    // coefficient of tap k for k up to the middle tap, the filter is symmetric about it; larger k read as zero
    function automatic logic signed [COEF_W-1:0] fdf_coef(input logic [HIST_AW-1:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            5'd0:    c = 16'sd2;
            5'd1:    c = 16'sd9;
            5'd2:    c = -16'sd12;
            5'd3:    c = -16'sd54;
            5'd4:    c = 16'sd16;
            5'd5:    c = 16'sd180;
            5'd6:    c = 16'sd45;
            5'd7:    c = -16'sd426;
            5'd8:    c = -16'sd303;
            5'd9:    c = 16'sd787;
            5'd10:   c = 16'sd991;
            5'd11:   c = -16'sd1191;
            5'd12:   c = -16'sd2691;
            5'd13:   c = 16'sd1514;
            5'd14:   c = 16'sd10144;
            5'd15:   c = 16'sd14746;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/fdf_queue.sv
// short item queue between the front classifier and the filter engine
// depends on fdf_pkg
`default_nettype none

module fdf_queue
    import fdf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire fdf_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output logic           q_valid,
    output fdf_item_t      q_item
);

    localparam int QPTR_W = (FDF_QUEUE_DEPTH > 1) ? $clog2(FDF_QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(FDF_QUEUE_DEPTH + 1);

    fdf_item_t           slot_reg [FDF_QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(FDF_QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(FDF_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(FDF_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/fdf_front.sv
// input side: takes samples, drops them while capture is off, tags every second one
// depends on fdf_pkg
`default_nettype none

module fdf_front
    import fdf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        capture_enable,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        q_full,
    output logic             push,
    output fdf_item_t        push_item
);

    logic phase_reg, phase_next;

    // disabled capture swallows transfers, otherwise wait for queue room
    assign s_tready = !capture_enable || !q_full;
    assign push     = s_tvalid && capture_enable && !q_full;

    assign push_item.sample  = $signed(s_tdata[31:16]);
    assign push_item.compute = !phase_reg;

    assign phase_next = push ? !phase_reg : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/fdf_back.sv
// filter engine: history memory, folded mac over tap pairs, rounding, framing, output register
// depends on fdf_pkg
`default_nettype none

module fdf_back
    import fdf_pkg::*;
#(
    parameter int FRAME_SAMPLES = FDF_FRAME_SAMPLES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire fdf_item_t   q_item,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);

    localparam int FRAME_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
    localparam int SH_W    = ACC_W - ROUND_SHIFT;

    fdf_state_t                 state_reg, state_next;
    logic [HIST_AW-1:0]         wp_reg, wp_next;
    logic [TAP_COUNT-1:0]       hvalid_reg, hvalid_next;
    logic [HIST_AW-1:0]         a_ptr_reg, a_ptr_next;
    logic [HIST_AW-1:0]         b_ptr_reg, b_ptr_next;
    logic [HIST_AW-1:0]         k_reg, k_next;
    logic                       rd_vld_reg, prod_vld_reg;
    logic                       rd_av_reg, rd_bv_reg;
    logic [HIST_AW-1:0]         rd_k_reg;
    logic [FRAME_W-1:0]         frame_reg, frame_next;
    logic                       out_vld_reg, out_vld_next;
    logic                       start;
    logic                       load_out;
    logic                       frame_end;

    logic signed [SAMPLE_W-1:0] hist_mem [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [15:0]         out_data_reg;
    logic                       out_last_reg;

    logic signed [SAMPLE_W-1:0] sa, sb;
    logic signed [SAMPLE_W:0]   pre_sum;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [SH_W-1:0]     shv;
    logic signed [15:0]         sat;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign pop       = (state_reg == BK_IDLE) && q_valid;
    assign start     = pop && q_item.compute;
    assign load_out  = (state_reg == BK_DONE) && (!out_vld_reg || m_tready);
    assign frame_end = (frame_reg == FRAME_W'(FRAME_SAMPLES - 1));

    // unwritten history slots read as zero, and the middle tap enters the pre-add only once
    always_comb
    begin
        sa      = rd_av_reg ? rd_a_reg : '0;
        sb      = (rd_bv_reg && (rd_k_reg != HIST_AW'(MID_TAP))) ? rd_b_reg : '0;
        pre_sum = (SAMPLE_W+1)'(sa) + (SAMPLE_W+1)'(sb);
    end

    // round half up, floor shift, clamp to int16
    always_comb
    begin
        rnd = acc_reg + ACC_W'(ROUND_BIAS);
        shv = $signed(rnd[ACC_W-1:ROUND_SHIFT]);
        if (shv > SH_W'(32767))
        begin
            sat = 16'sh7fff;
        end
        else if (shv < -SH_W'(32768))
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = shv[15:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        hvalid_next  = hvalid_reg;
        a_ptr_next   = a_ptr_reg;
        b_ptr_next   = b_ptr_reg;
        k_next       = k_reg;
        frame_next   = frame_reg;
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    hvalid_next[wp_reg] = 1'b1;
                    wp_next = (wp_reg == HIST_AW'(TAP_COUNT - 1)) ? '0 : wp_reg + 1'b1;
                    if (start)
                    begin
                        a_ptr_next = wp_reg;
                        b_ptr_next = (wp_reg == HIST_AW'(TAP_COUNT - 1)) ? '0 : wp_reg + 1'b1;
                        k_next     = '0;
                        state_next = BK_MAC;
                    end
                end
            end
            BK_MAC:
            begin
                a_ptr_next = (a_ptr_reg == '0) ? HIST_AW'(TAP_COUNT - 1) : a_ptr_reg - 1'b1;
                b_ptr_next = (b_ptr_reg == HIST_AW'(TAP_COUNT - 1)) ? '0 : b_ptr_reg + 1'b1;
                k_next     = k_reg + 1'b1;
                if (k_reg == HIST_AW'(MID_TAP))
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (load_out)
                begin
                    out_vld_next = 1'b1;
                    frame_next   = frame_end ? '0 : frame_reg + 1'b1;
                    state_next   = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            wp_reg       <= '0;
            hvalid_reg   <= '0;
            a_ptr_reg    <= '0;
            b_ptr_reg    <= '0;
            k_reg        <= '0;
            frame_reg    <= '0;
            out_vld_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            rd_av_reg    <= 1'b0;
            rd_bv_reg    <= 1'b0;
            rd_k_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            hvalid_reg   <= hvalid_next;
            a_ptr_reg    <= a_ptr_next;
            b_ptr_reg    <= b_ptr_next;
            k_reg        <= k_next;
            frame_reg    <= frame_next;
            out_vld_reg  <= out_vld_next;
            rd_vld_reg   <= (state_reg == BK_MAC);
            prod_vld_reg <= rd_vld_reg;
            rd_av_reg    <= hvalid_reg[a_ptr_reg];
            rd_bv_reg    <= hvalid_reg[b_ptr_reg];
            rd_k_reg     <= k_reg;
        end
    end

    // history memory, one write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hist_mem[wp_reg] <= q_item.sample;
        end
        rd_a_reg <= hist_mem[a_ptr_reg];
        rd_b_reg <= hist_mem[b_ptr_reg];
    end

    // pre-add, multiply, accumulate, output register load
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(pre_sum) * PROD_W'(fdf_coef(rd_k_reg));
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (load_out)
        begin
            out_data_reg <= sat;
            out_last_reg <= frame_end;
        end
    end

endmodule

`default_nettype wire

>>> sv/fir_decimator_by_two_framer_unit.sv
// top level of the half-rate 31-tap fir decimator with output framing
// depends on fdf_pkg, fdf_front, fdf_queue, fdf_back
// path from an odd input's transfer to its output: queue, 16 mac steps, read, product and
// accumulator registers, rounding, output register; one input per cycle into a 2-deep queue
// while it has room, drained by the single shared mac over 15 tap pairs and the middle tap
// reset (rst_n, async, active low): history reads as zero, phase, pointer, frame count and
// capture_enable cleared, queue and output register empty
`default_nettype none

module fir_decimator_by_two_framer_unit
    import fdf_pkg::*;
#(
    parameter int FRAME_SAMPLES = FDF_FRAME_SAMPLES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:16] left_sample
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] decimated_sample
    output logic             m_tlast,   // last_of_frame
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // capture_enable sits in bit 0 at addresses 0 to 3, address 4 and up hold nothing
    logic      capture_enable_reg, capture_enable_next;
    logic      reg_wr;

    logic      q_full;
    logic      push;
    fdf_item_t push_item;
    logic      pop;
    logic      q_valid;
    fdf_item_t q_item;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, capture_enable_reg};

    assign capture_enable_next = (reg_wr && !paddr[2]) ? pwdata[0] : capture_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_enable_reg <= 1'b0;
        end
        else
        begin
            capture_enable_reg <= capture_enable_next;
        end
    end

    // front: waits for queue room while capturing, keeps upper half, marks compute items
    fdf_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .capture_enable (capture_enable_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .q_full         (q_full),
        .push           (push),
        .push_item      (push_item)
    );

    // decouples input transfers from the mac loop
    fdf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // back: history write, filter, rounding, framing, output register
    fdf_back #(
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> sv/fdf_checker.sv
// port-level checks for the half-rate fir decimator, bound to the top level
// depends on fir_decimator_by_two_framer_unit_macros.svh
`default_nettype none
`include "fir_decimator_by_two_framer_unit_macros.svh"

module fdf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    logic cfg_wr;

    // access-phase write to the capture register
    assign cfg_wr = psel && penable && pwrite && !paddr[2];

    // a stalled output transfer keeps its valid and payload
    `FDF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `FDF_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    // capture_enable reads back what was last written
    `FDF_ASSERT_NXT(a_cfg_readback, cfg_wr, paddr[2] || (prdata[0] == $past(pwdata[0])))
    // only one register bit exists
    `FDF_ASSERT_IMP(a_cfg_upper_zero, psel, prdata[31:1] == 31'd0)

endmodule

bind fir_decimator_by_two_framer_unit fdf_checker u_fdf_checker (.*);

`default_nettype wire
